@@ rtl/rpra_pkg.sv @@
`default_nettype none

package rpra_pkg;

	localparam int ROWS_PER_HALF = 16;
	localparam int TOTAL_ROWS    = 2 * ROWS_PER_HALF;
	localparam int IDX_W         = $clog2(TOTAL_ROWS);
	localparam int ROW_W         = $clog2(ROWS_PER_HALF);

	localparam int WIN_W     = 5;
	localparam int KEY_W     = 16;
	localparam int CNT_W     = 16;
	localparam int ROW_OUT_W = 4;
	localparam int RIX_W     = 5;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam int UPPER_HALF_BIT = 11;

	localparam logic [KEY_W-1:0] NO_REUSE_MASK = 16'hF000;
	localparam logic [CNT_W-1:0] CNT_MAX       = 16'hFFFF;
	localparam logic [WIN_W-1:0] WIN_FIRST_RST = 5'd0;
	localparam logic [WIN_W-1:0] WIN_END_RST   = 5'd15;

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_REL_ROW = 2'd1,
		REQ_REL_KEY = 2'd2,
		REQ_LOOKUP  = 2'd3
	} req_t;

	typedef enum logic {
		REG_WIN_FIRST = 1'b0,
		REG_WIN_END   = 1'b1
	} reg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rewind;
		logic scan;
		logic bump;
		logic set_key;
		logic rel;
		logic hit;
		logic fallback;
		logic out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		req_t req;
		logic reuse_ok;
		logic scan_end;
		logic key_hit;
		logic cnt_zero;
		logic row_in_win;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/rpra_regs.sv @@
`default_nettype none

module rpra_regs import rpra_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output logic      [WIN_W-1:0]  win_first,
	output logic      [WIN_W-1:0]  win_end
);

	logic [WIN_W-1:0] win_first_q;
	logic [WIN_W-1:0] win_end_q;
	logic             wr_en;
	reg_idx_t         sel;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign sel    = reg_idx_t'(paddr[ADDR_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_first_q <= WIN_FIRST_RST;
			win_end_q   <= WIN_END_RST;
		end else if (wr_en) begin
			unique case (sel)
				REG_WIN_FIRST: win_first_q <= pwdata[WIN_W-1:0];
				REG_WIN_END:   win_end_q   <= pwdata[WIN_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_WIN_FIRST: prdata = DATA_W'(win_first_q);
			REG_WIN_END:   prdata = DATA_W'(win_end_q);
			default:       prdata = '0;
		endcase
	end

	assign win_first = win_first_q;
	assign win_end   = win_end_q;

endmodule

`default_nettype wire

@@ rtl/rpra_dp.sv @@
`default_nettype none

module rpra_dp import rpra_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [WIN_W-1:0]     win_first,
	input  wire logic [WIN_W-1:0]     win_end,
	input  wire logic [1:0]           req_type,
	input  wire logic [KEY_W-1:0]     key,
	input  wire logic [RIX_W-1:0]     row_index,
	input  wire dp_cmd_t              cmd,
	output dp_stat_t                  stat,
	output logic      [ROW_OUT_W-1:0] row_out,
	output logic                      found
);

	logic [KEY_W-1:0]     keys_q   [TOTAL_ROWS];
	logic [CNT_W-1:0]     counts_q [TOTAL_ROWS];

	req_t                 req_q;
	logic [KEY_W-1:0]     key_q;
	logic [RIX_W-1:0]     rix_q;
	logic [WIN_W-1:0]     r_q;
	logic [ROW_OUT_W-1:0] res_row_q;
	logic                 res_found_q;
	logic [ROW_OUT_W-1:0] row_out_q;
	logic                 found_q;

	logic [WIN_W-1:0]     first_c;
	logic [WIN_W-1:0]     end_c;
	logic [IDX_W-1:0]     scan_base;
	logic [IDX_W-1:0]     scan_idx;
	logic [ROW_OUT_W-1:0] rel_low;
	logic [IDX_W-1:0]     rel_base;
	logic [IDX_W-1:0]     rel_idx;
	logic [IDX_W-1:0]     idx;
	logic [KEY_W-1:0]     cur_key;
	logic [CNT_W-1:0]     cur_cnt;
	logic [CNT_W-1:0]     cnt_inc;
	logic [CNT_W-1:0]     cnt_dec;

	// window bounds saturate at the half size
	assign first_c = (win_first > WIN_W'(ROWS_PER_HALF)) ? WIN_W'(ROWS_PER_HALF) : win_first;
	assign end_c   = (win_end > WIN_W'(ROWS_PER_HALF)) ? WIN_W'(ROWS_PER_HALF) : win_end;

	assign scan_base = key_q[UPPER_HALF_BIT] ? IDX_W'(ROWS_PER_HALF) : '0;
	assign scan_idx  = scan_base + IDX_W'(r_q[ROW_W-1:0]);

	assign rel_low  = rix_q[ROW_OUT_W-1:0];
	assign rel_base = rix_q[RIX_W-1] ? IDX_W'(ROWS_PER_HALF) : '0;
	assign rel_idx  = rel_base + IDX_W'(rel_low[ROW_W-1:0]);

	assign idx     = (req_q == REQ_REL_ROW) ? rel_idx : scan_idx;
	assign cur_key = keys_q[idx];
	assign cur_cnt = counts_q[idx];

	assign cnt_inc = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + CNT_W'(1);
	assign cnt_dec = (cur_cnt == '0) ? '0 : cur_cnt - CNT_W'(1);

	always_comb begin
		stat.req        = req_q;
		stat.reuse_ok   = (key_q & NO_REUSE_MASK) == '0;
		stat.scan_end   = r_q >= end_c;
		stat.key_hit    = cur_key == key_q;
		stat.cnt_zero   = cur_cnt == '0;
		stat.row_in_win = (WIN_W'(rel_low) >= first_c) && (WIN_W'(rel_low) < end_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOTAL_ROWS; i++) begin
				keys_q[i]   <= '0;
				counts_q[i] <= '0;
			end
		end else begin
			if (cmd.bump) begin
				counts_q[idx] <= cnt_inc;
			end
			if (cmd.set_key) begin
				keys_q[idx] <= key_q;
			end
			if (cmd.rel) begin
				counts_q[idx] <= cnt_dec;
				if (cnt_dec == '0) begin
					keys_q[idx] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q       <= req_t'(req_type);
			key_q       <= key;
			rix_q       <= row_index;
			r_q         <= first_c;
			res_row_q   <= '0;
			res_found_q <= 1'b0;
		end
		if (cmd.rewind) begin
			r_q <= first_c;
		end
		if (cmd.scan) begin
			r_q <= r_q + WIN_W'(1);
		end
		if (cmd.hit) begin
			res_row_q   <= ROW_OUT_W'(r_q);
			res_found_q <= 1'b1;
		end
		// window full: last row of the window, or first - 1 when empty
		if (cmd.fallback) begin
			res_row_q   <= ROW_OUT_W'(r_q - WIN_W'(1));
			res_found_q <= 1'b0;
		end
		if (cmd.out_load) begin
			row_out_q <= res_row_q;
			found_q   <= res_found_q;
		end
	end

	assign row_out = row_out_q;
	assign found   = found_q;

endmodule

`default_nettype wire

@@ rtl/rpra_ctrl.sv @@
`default_nettype none

module rpra_ctrl import rpra_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire logic [1:0] req_type,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	input  wire dp_stat_t   stat,
	output dp_cmd_t         cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_MATCH  = 6'b000010,
		S_FREE   = 6'b000100,
		S_RELKEY = 6'b001000,
		S_RELROW = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					unique case (req_t'(req_type)) inside
						REQ_ALLOC, REQ_LOOKUP: state_d = S_MATCH;
						REQ_REL_ROW:           state_d = S_RELROW;
						REQ_REL_KEY:           state_d = S_RELKEY;
						default:               state_d = S_IDLE;
					endcase
				end
			end
			S_MATCH: begin
				// allocate falls through to the free-row scan
				if (stat.req == REQ_ALLOC && (!stat.reuse_ok || stat.scan_end)) begin
					cmd.rewind = 1'b1;
					state_d    = S_FREE;
				end else if (stat.scan_end) begin
					state_d = S_DONE;
				end else if (stat.key_hit) begin
					cmd.hit  = 1'b1;
					cmd.bump = stat.req == REQ_ALLOC;
					state_d  = S_DONE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_FREE: begin
				if (stat.scan_end) begin
					cmd.fallback = 1'b1;
					state_d      = S_DONE;
				end else if (stat.cnt_zero) begin
					cmd.bump    = 1'b1;
					cmd.set_key = 1'b1;
					cmd.hit     = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_RELKEY: begin
				if (stat.scan_end) begin
					state_d = S_DONE;
				end else begin
					cmd.scan = 1'b1;
					cmd.rel  = stat.key_hit;
				end
			end
			S_RELROW: begin
				cmd.rel = stat.row_in_win;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q != S_IDLE))
		else $error("accepted beat did not start work");

	a_no_scan_past_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> !stat.scan_end)
		else $error("scan advanced past window end");

	a_bump_rel_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.bump && cmd.rel))
		else $error("increment and release in one cycle");

	a_done_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rsp_valid_q && !rsp_ready) |=> (state_q == S_DONE))
		else $error("result overwrote a pending beat");

endmodule

`default_nettype wire

@@ rtl/refcounted_palette_row_allocator_core.sv @@
`default_nettype none

// Reference-counted palette row allocator: two halves of ROWS_PER_HALF rows, each row holding a
// 16-bit key and a saturating 16-bit use count, all cleared by reset. Requests are allocate,
// release by row, release by key and lookup by key; each gives exactly one response beat
// (row_out, found). The window registers (first row at 0x0, end row at 0x4) should only be
// written while the block is idle. A request is handled one at a time by a controller that
// steps a single row pointer through the window, one row per cycle: release by row checks
// one row, lookup and release by key scan the window, and allocate scans for a match and,
// failing one, for a free row. A new request is accepted while the previous response still
// waits in the output register.
module refcounted_palette_row_allocator_core import rpra_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_W-1:0]    paddr,
	input  wire logic [DATA_W-1:0]    pwdata,
	output logic      [DATA_W-1:0]    prdata,
	output logic                      pready,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire logic [1:0]           req_type,
	input  wire logic [KEY_W-1:0]     key,
	input  wire logic [RIX_W-1:0]     row_index,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output logic      [ROW_OUT_W-1:0] row_out,
	output logic                      found
);

	logic [WIN_W-1:0] win_first;
	logic [WIN_W-1:0] win_end;
	dp_cmd_t          cmd;
	dp_stat_t         stat;

	rpra_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.win_first (win_first),
		.win_end   (win_end)
	);

	rpra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_type),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rpra_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_first (win_first),
		.win_end   (win_end),
		.req_type  (req_type),
		.key       (key),
		.row_index (row_index),
		.cmd       (cmd),
		.stat      (stat),
		.row_out   (row_out),
		.found     (found)
	);

endmodule

`default_nettype wire

@@ dv/refcounted_palette_row_allocator_core_tb.sv @@
`timescale 1ns / 100ps

module refcounted_palette_row_allocator_core_tb;
	import rpra_pkg::*;

	typedef struct packed {
		logic [ROW_OUT_W-1:0] row;
		logic                 hit;
	} grant_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 psel      = 1'b0;
	logic                 penable   = 1'b0;
	logic                 pwrite    = 1'b0;
	logic [ADDR_W-1:0]    paddr     = '0;
	logic [DATA_W-1:0]    pwdata    = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	logic [1:0]           req_type  = '0;
	logic [KEY_W-1:0]     key       = '0;
	logic [RIX_W-1:0]     row_index = '0;
	logic                 rsp_valid;
	logic                 rsp_ready;
	logic [ROW_OUT_W-1:0] row_out;
	logic                 found;

	// shadow copy of the row stores and window registers
	logic [KEY_W-1:0] shadow_keys   [TOTAL_ROWS];
	logic [CNT_W-1:0] shadow_counts [TOTAL_ROWS];
	logic [WIN_W-1:0] shadow_first;
	logic [WIN_W-1:0] shadow_end;

	grant_t grant_q[$];

	int err_count   = 0;
	int n_sent      = 0;
	int n_checked   = 0;
	int n_windows   = 0;
	int stall_left  = 0;
	int rsp_idle    = 0;
	bit req_gaps_on = 1'b0;
	bit rsp_gaps_on = 1'b0;

	refcounted_palette_row_allocator_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_type),
		.key       (key),
		.row_index (row_index),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.row_out   (row_out),
		.found     (found)
	);

	always #10 clk = ~clk;

	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 14)
			return $urandom_range(1, 3);
		else if (roll < 19)
			return $urandom_range(4, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic void release_row(int idx);
		if (shadow_counts[idx] != '0)
			shadow_counts[idx] = shadow_counts[idx] - 1'b1;
		if (shadow_counts[idx] == '0)
			shadow_keys[idx] = '0;
	endfunction

	function automatic void bump_row(int idx);
		if (shadow_counts[idx] != CNT_MAX)
			shadow_counts[idx] = shadow_counts[idx] + 1'b1;
	endfunction

	// applies one request to the shadow rows, returns the response it should give
	function automatic grant_t calc_row_grant(req_t rt, logic [KEY_W-1:0] k,
			logic [RIX_W-1:0] ri);
		int first;
		int stop;
		int base;
		int hbase;
		int low;
		int r;
		bit done;
		grant_t g;
		first = (shadow_first > ROWS_PER_HALF) ? ROWS_PER_HALF : int'(shadow_first);
		stop  = (shadow_end > ROWS_PER_HALF) ? ROWS_PER_HALF : int'(shadow_end);
		base  = k[UPPER_HALF_BIT] ? ROWS_PER_HALF : 0;
		g     = '0;
		done  = 1'b0;
		case (rt)
			REQ_ALLOC: begin
				if ((k & NO_REUSE_MASK) == '0) begin
					r = first;
					while (!done && r < stop) begin
						if (shadow_keys[base + r] == k) begin
							bump_row(base + r);
							g.row = ROW_OUT_W'(r);
							g.hit = 1'b1;
							done  = 1'b1;
						end else begin
							r++;
						end
					end
				end
				if (!done) begin
					r = first;
					while (r < stop && shadow_counts[base + r] != '0)
						r++;
					// no free row: last row of the window, or first - 1 when empty; nothing changes
					if (r >= stop) begin
						g.row = ROW_OUT_W'(r + 15);
					end else begin
						bump_row(base + r);
						shadow_keys[base + r] = k;
						g.row = ROW_OUT_W'(r);
						g.hit = 1'b1;
					end
				end
			end
			REQ_REL_ROW: begin
				low   = int'(ri[3:0]);
				hbase = ri[4] ? ROWS_PER_HALF : 0;
				if (low >= first && low < stop)
					release_row(hbase + low);
			end
			REQ_REL_KEY: begin
				for (r = first; r < stop; r++)
					if (shadow_keys[base + r] == k)
						release_row(base + r);
			end
			default: begin
				r = first;
				while (!done && r < stop) begin
					if (shadow_keys[base + r] == k) begin
						g.row = ROW_OUT_W'(r);
						g.hit = 1'b1;
						done  = 1'b1;
					end else begin
						r++;
					end
				end
			end
		endcase
		return g;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		err_count++;
	endtask

	// response side: random idling plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_idle  <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ready  <= 1'b0;
		end else if (rsp_idle > 0) begin
			rsp_idle  <= rsp_idle - 1;
			rsp_ready <= 1'b0;
		end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
			rsp_idle  <= gap_len() - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			n_checked++;
			if (grant_q.size() == 0) begin
				report_mismatch($sformatf("unexpected response beat: row_out %0d found %0b",
					row_out, found));
			end else begin
				want = grant_q.pop_front();
				if (row_out !== want.row)
					report_mismatch($sformatf("row_out %0d, want %0d", row_out, want.row));
				if (found !== want.hit)
					report_mismatch($sformatf("found %0b, want %0b", found, want.hit));
			end
		end
	end

	task automatic send_req(req_t rt, logic [KEY_W-1:0] k, logic [RIX_W-1:0] ri);
		int g;
		req_valid <= 1'b1;
		req_type  <= rt;
		key       <= k;
		row_index <= ri;
		do @(posedge clk); while (!req_ready);
		grant_q.push_back(calc_row_grant(rt, k, ri));
		n_sent++;
		if (req_gaps_on && $urandom_range(0, 2) == 0) begin
			g = gap_len();
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (grant_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t r, logic [DATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(int'(r) * 4);
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (r == REG_WIN_FIRST)
			shadow_first = v[WIN_W-1:0];
		else
			shadow_end = v[WIN_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read_check(reg_idx_t r, logic [WIN_W-1:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_W'(int'(r) * 4);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== DATA_W'(want))
			report_mismatch($sformatf("register %s reads 0x%0h, want 0x%0h",
				r.name(), prdata, want));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// upper data bits are random and must be dropped by the register
	task automatic set_window(logic [WIN_W-1:0] first, logic [WIN_W-1:0] stop);
		apb_write(REG_WIN_FIRST, {(DATA_W-WIN_W)'($urandom), first});
		apb_write(REG_WIN_END, {(DATA_W-WIN_W)'($urandom), stop});
		apb_read_check(REG_WIN_FIRST, first);
		apb_read_check(REG_WIN_END, stop);
		n_windows++;
	endtask

	task automatic test_reset_window_ops();
		apb_read_check(REG_WIN_FIRST, WIN_FIRST_RST);
		apb_read_check(REG_WIN_END, WIN_END_RST);
		// free rows hold key 0, so key 0 hits them
		send_req(REQ_LOOKUP, 16'h0000, 5'd0);
		send_req(REQ_ALLOC, 16'h0000, 5'd0);
		send_req(REQ_ALLOC, 16'h0123, 5'd31);
		send_req(REQ_ALLOC, 16'h0123, 5'd0);
		send_req(REQ_ALLOC, 16'hF123, 5'd0);
		send_req(REQ_ALLOC, 16'h0923, 5'd0);
		send_req(REQ_ALLOC, 16'hFFFF, 5'd31);
		send_req(REQ_LOOKUP, 16'h0123, 5'd0);
		send_req(REQ_LOOKUP, 16'h7999, 5'd0);
		send_req(REQ_REL_ROW, 16'h0000, 5'd1);
		send_req(REQ_REL_KEY, 16'h0123, 5'd0);
		send_req(REQ_LOOKUP, 16'h0123, 5'd0);
		send_req(REQ_REL_ROW, 16'hFFFF, 5'h10);
		send_req(REQ_REL_ROW, 16'h0000, 5'h1F);
		send_req(REQ_REL_KEY, 16'hFFFF, 5'd31);
		send_req(REQ_LOOKUP, 16'hFFFF, 5'd0);
		wait_drained();
	endtask

	// repeated allocation of one key stacks its use count; the row stays
	// claimed until the last use is released
	task automatic test_count_stacking();
		set_window(5'd15, 5'd16);
		repeat (8)
			send_req(REQ_ALLOC, 16'h0555, RIX_W'($urandom));
		repeat (7)
			send_req(REQ_REL_ROW, 16'h0000, 5'd15);
		send_req(REQ_LOOKUP, 16'h0555, 5'd0);
		send_req(REQ_REL_ROW, 16'h0000, 5'd15);
		send_req(REQ_LOOKUP, 16'h0555, 5'd0);
		wait_drained();
	endtask

	task automatic test_window_bounds();
		set_window(5'd2, 5'd4);
		send_req(REQ_ALLOC, 16'h1000, 5'd0);
		send_req(REQ_ALLOC, 16'h2000, 5'd0);
		send_req(REQ_ALLOC, 16'h3000, 5'd0);
		send_req(REQ_ALLOC, 16'h0000, 5'd0);
		send_req(REQ_REL_KEY, 16'h1000, 5'd0);
		send_req(REQ_LOOKUP, 16'h2000, 5'd0);
		send_req(REQ_REL_ROW, 16'h0000, 5'd3);
		wait_drained();
		set_window(5'd16, 5'd16);
		send_req(REQ_ALLOC, 16'h0042, 5'd0);
		send_req(REQ_LOOKUP, 16'h0000, 5'd0);
		wait_drained();
		set_window(5'd0, 5'd0);
		send_req(REQ_ALLOC, 16'h0042, 5'd0);
		wait_drained();
		set_window(5'd9, 5'd5);
		send_req(REQ_ALLOC, 16'h0842, 5'd0);
		send_req(REQ_REL_ROW, 16'h0000, 5'd7);
		wait_drained();
		set_window(5'd31, 5'd31);
		send_req(REQ_ALLOC, 16'h0042, 5'd0);
		wait_drained();
		set_window(5'd0, 5'd31);
		send_req(REQ_ALLOC, 16'h08FF, 5'd0);
		send_req(REQ_LOOKUP, 16'h0923, 5'd0);
		send_req(REQ_REL_ROW, 16'h0000, 5'd31);
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		set_window(5'd0, 5'd8);
		req_gaps_on = 1'b0;
		rsp_gaps_on = 1'b0;
		stall_left  = 300;
		// input must stall once the output beat is stuck
		repeat (24)
			send_req(req_t'($urandom_range(0, 3)), {4'h0, 1'b0, 11'($urandom_range(0, 3))},
				RIX_W'($urandom_range(0, 7)));
		while (stall_left != 0)
			@(posedge clk);
		wait_drained();
		repeat (12)
			send_req(req_t'($urandom_range(0, 3)), {4'h0, 1'b0, 11'($urandom_range(0, 3))},
				RIX_W'($urandom_range(0, 7)));
		wait_drained();
	endtask

	task automatic test_random_traffic();
		logic [KEY_W-1:0] pool [6];
		logic [WIN_W-1:0] wf;
		logic [WIN_W-1:0] we;
		logic [KEY_W-1:0] k;
		logic [RIX_W-1:0] ri;
		int span;
		int roll;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin wf = 5'd0;  we = 5'd16; end
				1: begin wf = 5'd0;  we = 5'd4;  end
				2: begin wf = 5'd12; we = 5'd16; end
				3: begin wf = 5'd3;  we = 5'd3;  end
				4: begin wf = 5'd0;  we = 5'd15; end
				default: begin
					wf = WIN_W'($urandom_range(0, 12));
					we = wf + WIN_W'($urandom_range(1, 4));
				end
			endcase
			set_window(wf, we);
			req_gaps_on = (phase % 3) != 0;
			rsp_gaps_on = (phase % 3) != 0;
			for (int i = 0; i < 6; i++) begin
				pool[i] = KEY_W'($urandom);
				if ($urandom_range(0, 3) != 0)
					pool[i][15:12] = 4'h0;
			end
			pool[0] = (phase == 4) ? 16'h0000 : pool[0];
			span = (we > wf) ? int'(we) - int'(wf) : 0;
			repeat (60) begin
				roll = $urandom_range(0, 99);
				k    = pool[$urandom_range(0, 5)];
				ri   = RIX_W'($urandom);
				if (span > 0 && $urandom_range(0, 1) == 0)
					ri[3:0] = 4'(int'(wf) + $urandom_range(0, span - 1));
				if (roll < 10)
					send_req(req_t'($urandom_range(0, 3)), KEY_W'($urandom), ri);
				else if (roll < 50)
					send_req(REQ_ALLOC, k, ri);
				else if (roll < 65)
					send_req(REQ_REL_ROW, k, ri);
				else if (roll < 80)
					send_req(REQ_REL_KEY, k, ri);
				else
					send_req(REQ_LOOKUP, k, ri);
			end
			wait_drained();
		end
	endtask

	initial begin
		int spins;
		for (int i = 0; i < TOTAL_ROWS; i++) begin
			shadow_keys[i]   = '0;
			shadow_counts[i] = '0;
		end
		shadow_first = WIN_FIRST_RST;
		shadow_end   = WIN_END_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window_ops();
		test_count_stacking();
		test_window_bounds();
		test_output_backpressure();
		test_random_traffic();

		req_valid <= 1'b0;
		spins = 0;
		while (grant_q.size() != 0 && spins < 20000) begin
			@(posedge clk);
			spins++;
		end
		if (grant_q.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", grant_q.size()));
		repeat (40) @(posedge clk);

		$display("checked %0d response beats for %0d requests over %0d window settings",
			n_checked, n_sent, n_windows);
		$display("covered stacked use counts, full and empty windows, and a long output stall");
		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#50000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
